FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ihex_dec_pkg.sv
// Shared constants for the HEX record decoder: address width and result kind codes.
package ihex_dec_pkg;

    localparam int ADDRESS_BITS = 20;
    localparam int ADDR_W       = 20;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    localparam logic [2:0] KIND_DATA  = 3'd0;
    localparam logic [2:0] KIND_END   = 3'd1;
    localparam logic [2:0] KIND_SEG   = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_EMPTY = 3'd4;

endpackage

FILE: design/intel_hex_record_decoder.sv
// HEX record decoder: one text character per beat in, at most one result out per character.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------------
//   in      | in_valid, in_stall   | text_char
//   out     | out_valid, out_stall | kind, byte_address, data_byte, last_of_record,
//           |                      | record_length
//
// One character per cycle sustained unless a stalled result register holds the input.
// The character register feeds the parser logic, which writes the result register.
// in_stall rises only while a character that makes a result waits on a full, stalled
// result register; characters that make no result pass through regardless.
// rst_n clears the parser state and both valid flags at once.
module intel_hex_record_decoder
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       text_char,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       kind,
    output logic [ihex_dec_pkg::ADDR_W-1:0]  byte_address,
    output logic [7:0]                       data_byte,
    output logic                             last_of_record,
    output logic [7:0]                       record_length
);

    typedef enum logic [2:0] {
        PH_COLON,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_SEG,
        PH_DATA,
        PH_SKIP
    } phase_t;

    localparam logic [7:0]  CH_COLON   = 8'h3A;
    localparam logic [7:0]  CH_NEWLINE = 8'h0A;
    localparam logic [15:0] REC_DATA   = 16'd0;
    localparam logic [15:0] REC_END    = 16'd1;
    localparam logic [15:0] REC_SEG    = 16'd2;

    function automatic logic [4:0] digit_decode(input logic [7:0] c);
        logic       bad;
        logic [3:0] val;
        bad = 1'b0;
        val = 4'd0;
        if (c >= 8'h61)
        begin
            bad = (c > 8'h66);
            val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41)
        begin
            bad = (c > 8'h46);
            val = 4'(c - 8'h37);
        end
        else if (c >= 8'h30 && c <= 8'h3F)
        begin
            val = c[3:0];
        end
        else
        begin
            bad = 1'b1;
        end
        return {bad, val};
    endfunction

    phase_t                            phase_reg, phase_next;
    logic [1:0]                        dpos_reg, dpos_next;
    logic [15:0]                       acc_reg, acc_next;
    logic [7:0]                        count_reg, count_next;
    logic [15:0]                       start_addr_reg, start_addr_next;
    logic [7:0]                        left_reg, left_next;
    logic [7:0]                        index_reg, index_next;
    logic [3:0]                        base_reg, base_next;

    logic                              in_valid_reg;
    logic [7:0]                        char_reg;

    logic                              out_valid_reg;
    logic [2:0]                        kind_reg, kind_next;
    logic [ihex_dec_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [7:0]                        data_reg, data_next;
    logic                              last_reg, last_next;
    logic [7:0]                        len_reg, len_next;

    logic                              res_valid;
    logic                              advance;
    logic                              fire;
    logic                              take;
    logic [4:0]                        dig;
    logic [15:0]                       acc_shift;
    logic                              field_done;
    logic                              is_newline;
    logic [ihex_dec_pkg::ADDR_W-1:0]   addr_sum;

    assign dig        = digit_decode(char_reg);
    assign acc_shift  = {acc_reg[11:0], dig[3:0]};
    assign is_newline = (char_reg == CH_NEWLINE);
    assign field_done = (phase_reg == PH_ADDR || phase_reg == PH_SEG) ?
                        (dpos_reg == 2'd3) : (dpos_reg == 2'd1);
    assign addr_sum   = {base_reg, 16'h0000}
                      + ihex_dec_pkg::ADDR_W'(start_addr_reg)
                      + ihex_dec_pkg::ADDR_W'(index_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        dpos_next       = dpos_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        start_addr_next = start_addr_reg;
        left_next       = left_reg;
        index_next      = index_reg;
        base_next       = base_reg;
        res_valid       = 1'b0;
        kind_next       = ihex_dec_pkg::KIND_ERROR;
        addr_next       = '0;
        data_next       = 8'd0;
        last_next       = 1'b0;
        len_next        = count_reg;

        unique case (phase_reg)
            PH_COLON:
            begin
                count_next = 8'd0;
                len_next   = 8'd0;
                if (char_reg == CH_COLON)
                begin
                    phase_next = PH_COUNT;
                    dpos_next  = 2'd0;
                    acc_next   = 16'd0;
                end
                else
                begin
                    phase_next = is_newline ? PH_COLON : PH_SKIP;
                    dpos_next  = 2'd0;
                    acc_next   = 16'd0;
                    res_valid  = 1'b1;
                end
            end
            PH_SKIP:
            begin
                if (is_newline)
                begin
                    phase_next = PH_COLON;
                end
            end
            PH_COUNT, PH_ADDR, PH_TYPE, PH_SEG, PH_DATA:
            begin
                if (dig[4])
                begin
                    phase_next = is_newline ? PH_COLON : PH_SKIP;
                    dpos_next  = 2'd0;
                    acc_next   = 16'd0;
                    res_valid  = 1'b1;
                end
                else if (!field_done)
                begin
                    dpos_next = dpos_reg + 2'd1;
                    acc_next  = acc_shift;
                end
                else
                begin
                    dpos_next = 2'd0;
                    acc_next  = 16'd0;
                    unique case (phase_reg)
                        PH_COUNT:
                        begin
                            count_next = acc_shift[7:0];
                            phase_next = PH_ADDR;
                        end
                        PH_ADDR:
                        begin
                            start_addr_next = acc_shift;
                            phase_next      = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            priority if (acc_shift == REC_DATA)
                            begin
                                if (count_reg == 8'd0)
                                begin
                                    phase_next = PH_SKIP;
                                    res_valid  = 1'b1;
                                    kind_next  = ihex_dec_pkg::KIND_EMPTY;
                                end
                                else
                                begin
                                    left_next  = count_reg;
                                    index_next = 8'd0;
                                    phase_next = PH_DATA;
                                end
                            end
                            else if (acc_shift == REC_END)
                            begin
                                phase_next = PH_SKIP;
                                res_valid  = 1'b1;
                                kind_next  = ihex_dec_pkg::KIND_END;
                            end
                            else if (acc_shift == REC_SEG)
                            begin
                                phase_next = PH_SEG;
                            end
                            else
                            begin
                                phase_next = PH_SKIP;
                                res_valid  = 1'b1;
                            end
                        end
                        PH_SEG:
                        begin
                            base_next  = acc_shift[15:12];
                            phase_next = PH_SKIP;
                            res_valid  = 1'b1;
                            kind_next  = ihex_dec_pkg::KIND_SEG;
                        end
                        default:
                        begin
                            left_next  = left_reg - 8'd1;
                            index_next = index_reg + 8'd1;
                            res_valid  = 1'b1;
                            kind_next  = ihex_dec_pkg::KIND_DATA;
                            addr_next  = addr_sum & ihex_dec_pkg::ADDR_MASK;
                            data_next  = acc_shift[7:0];
                            if (left_reg == 8'd1)
                            begin
                                last_next  = 1'b1;
                                phase_next = PH_SKIP;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = PH_COLON;
            end
        endcase
    end

    assign advance  = !res_valid || !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_COLON;
            dpos_reg       <= 2'd0;
            acc_reg        <= 16'd0;
            count_reg      <= 8'd0;
            start_addr_reg <= 16'd0;
            left_reg       <= 8'd0;
            index_reg      <= 8'd0;
            base_reg       <= 4'd0;
            in_valid_reg   <= 1'b0;
            char_reg       <= 8'd0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= ihex_dec_pkg::KIND_DATA;
            addr_reg       <= '0;
            data_reg       <= 8'd0;
            last_reg       <= 1'b0;
            len_reg        <= 8'd0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
                char_reg     <= text_char;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                phase_reg      <= phase_next;
                dpos_reg       <= dpos_next;
                acc_reg        <= acc_next;
                count_reg      <= count_next;
                start_addr_reg <= start_addr_next;
                left_reg       <= left_next;
                index_reg      <= index_next;
                base_reg       <= base_next;
            end

            if (fire && res_valid)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= kind_next;
                addr_reg      <= addr_next;
                data_reg      <= data_next;
                last_reg      <= last_next;
                len_reg       <= len_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign byte_address   = addr_reg;
    assign data_byte      = data_reg;
    assign last_of_record = last_reg;
    assign record_length  = len_reg;

endmodule

FILE: design/ihex_dec_checker.sv
// Port-level checks for the HEX record decoder, bound into the decoder module.
`include "assert_macros.svh"

module ihex_dec_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [7:0]                       text_char,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [2:0]                       kind,
    input  logic [ihex_dec_pkg::ADDR_W-1:0]  byte_address,
    input  logic [7:0]                       data_byte,
    input  logic                             last_of_record,
    input  logic [7:0]                       record_length
);

    // a held result keeps its payload
    `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(kind) && $stable(byte_address) && $stable(data_byte) && $stable(last_of_record) && $stable(record_length), "stalled result changed")

    // input backpressure only comes from a blocked result register
    `CHK_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled while output free")

    // a new result always traces back to a beat taken into the character register
    `CHK_ASSERT(a_result_source, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without input beat")

    // address, data and last flag are zero on anything but a data byte
    `CHK_ASSERT_ALWAYS(a_nondata_zero, out_valid && kind != ihex_dec_pkg::KIND_DATA |-> byte_address == '0 && data_byte == 8'd0 && !last_of_record, "non-data result carries data fields")

endmodule

bind intel_hex_record_decoder ihex_dec_checker u_ihex_dec_checker (.*);
